// File: src/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg: shared types and constants of the line rasterizer
// Coordinate, error and address widths, the command handed from the front
// end to the stepping engine, and a small span helper.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int COORD_BITS    = 9;
  localparam int ERR_BITS      = COORD_BITS + 2;
  localparam int COLOR_BITS    = 16;
  localparam int ADDR_BITS     = 32;
  localparam int FRAME_ROWS    = 240;
  localparam int ROW_SHIFT     = 10;

  // Command queue between front end and stepping engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Request kinds carried on the input tuser bit
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  // One classified request, with the line setup already worked out for loads
  typedef struct packed {
    logic   is_load;
    logic   steep;
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    coord_t major_delta;
    coord_t minor_delta;
    logic   minor_dir;
    color_t color;
  } cmd_t;

  // Absolute difference of two coordinates
  function automatic coord_t span(input coord_t a, input coord_t b);
    span = (a > b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

endpackage

// File: src/blr_front.sv
// ----------------------------------------------------------------------------
// blr_front: request intake and line setup
// Accepts stream requests, classifies load versus step, and for a load picks
// the major axis, orders the endpoints and forms the deltas.
// ----------------------------------------------------------------------------
module blr_front import blr_pkg::*; (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // x_start, y_start, x_end, y_end, color
  input  logic [0:0]  s_axis_tuser,   // action
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  coord_t xa, ya, xb, yb;
  coord_t ma, na, mb, nb;
  coord_t dx, dy;
  logic   steep;

  // Unpack the request
  assign xa = s_axis_tdata[8:0];
  assign ya = s_axis_tdata[17:9];
  assign xb = s_axis_tdata[26:18];
  assign yb = s_axis_tdata[35:27];

  // Take a request whenever the queue has room
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  assign dx    = span(xa, xb);
  assign dy    = span(ya, yb);
  assign steep = dy > dx;

  // Swap axes for a steep line, then order endpoints by the major axis
  always_comb begin
    coord_t m0, n0, m1, n1;
    m0 = steep ? ya : xa;
    n0 = steep ? xa : ya;
    m1 = steep ? yb : xb;
    n1 = steep ? xb : yb;
    if (m0 > m1) begin
      ma = m1; na = n1; mb = m0; nb = n0;
    end else begin
      ma = m0; na = n0; mb = m1; nb = n1;
    end
  end

  // Build the queue entry
  always_comb begin
    q_cmd.is_load     = (s_axis_tuser[0] == ACT_LOAD);
    q_cmd.steep       = steep;
    q_cmd.major_pos   = ma;
    q_cmd.major_end   = mb;
    q_cmd.minor_pos   = na;
    q_cmd.major_delta = coord_t'(mb - ma);
    q_cmd.minor_delta = span(na, nb);
    q_cmd.minor_dir   = !(na < nb);
    q_cmd.color       = s_axis_tdata[51:36];
  end

endmodule

// File: src/blr_queue.sv
// ----------------------------------------------------------------------------
// blr_queue: command queue
// Small register queue that lets intake and stepping stall independently.
// ----------------------------------------------------------------------------
module blr_queue import blr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head_cmd
);

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_BITS'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_BITS'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_BITS'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_BITS'(count - 1'b1);
      end
    end
  end

  // Hold entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: src/blr_back.sv
// ----------------------------------------------------------------------------
// blr_back: Bresenham stepping engine
// Holds the line state, executes queued loads and steps, and drives the
// registered pixel output stream.
// ----------------------------------------------------------------------------
module blr_back import blr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  addr_t       buffer_base,
  input  logic        q_not_empty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_color, pixel_address
  output logic        m_axis_tlast    // last_pixel
);

  localparam addr_t ROW_TOP = ADDR_BITS'(FRAME_ROWS - 1);

  // Line state
  logic   busy;
  logic   steep;
  coord_t major_pos;
  coord_t major_end;
  coord_t minor_pos;
  coord_t major_delta;
  coord_t minor_delta;
  err_t   error_acc;
  logic   minor_dir;
  color_t draw_color;

  // Output register
  logic   out_valid;
  coord_t out_x;
  coord_t out_y;
  color_t out_color;
  addr_t  out_addr;
  logic   out_last;

  logic   out_free;
  logic   do_load;
  logic   do_pixel;
  coord_t px;
  coord_t py;
  logic   last;
  addr_t  row_off;
  addr_t  addr;
  err_t   err_sum;
  err_t   err_next;
  logic   minor_move;

  // Pop when the request can complete this cycle
  assign out_free = !out_valid || m_axis_tready;
  assign q_pop    = q_not_empty && (q_cmd.is_load || !busy || out_free);
  assign do_load  = q_pop && q_cmd.is_load;
  assign do_pixel = q_pop && !q_cmd.is_load && busy;

  // Current pixel in original orientation and its buffer address
  assign px      = steep ? minor_pos : major_pos;
  assign py      = steep ? major_pos : minor_pos;
  assign last    = (major_pos == major_end);
  assign row_off = addr_t'((ROW_TOP - addr_t'(py)) << ROW_SHIFT);
  assign addr    = addr_t'(buffer_base + row_off + addr_t'({px, 1'b0}));

  // Error update: step the minor axis when the error goes positive
  assign err_sum    = err_t'($signed(error_acc) + $signed({2'b00, minor_delta}));
  assign minor_move = ($signed(err_sum) > $signed(err_t'(0)));
  assign err_next   = minor_move ? err_t'(err_sum - {2'b00, major_delta}) : err_sum;

  // Load a line or advance one pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (do_load) begin
      busy <= 1'b1;
    end else if (do_pixel && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      steep       <= q_cmd.steep;
      major_pos   <= q_cmd.major_pos;
      major_end   <= q_cmd.major_end;
      minor_pos   <= q_cmd.minor_pos;
      major_delta <= q_cmd.major_delta;
      minor_delta <= q_cmd.minor_delta;
      minor_dir   <= q_cmd.minor_dir;
      draw_color  <= q_cmd.color;
      error_acc   <= err_t'(err_t'(0) - err_t'(q_cmd.major_delta >> 1));
    end else if (do_pixel) begin
      error_acc <= err_next;
      if (minor_move) begin
        minor_pos <= minor_dir ? coord_t'(minor_pos - 1'b1) : coord_t'(minor_pos + 1'b1);
      end
      if (!last) begin
        major_pos <= coord_t'(major_pos + 1'b1);
      end
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_pixel) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pixel) begin
      out_x     <= px;
      out_y     <= py;
      out_color <= draw_color;
      out_addr  <= addr;
      out_last  <= last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_addr, out_color, out_y, out_x};
  assign m_axis_tlast  = out_last;

endmodule

// File: src/bresenham_line_rasterizer_top.sv
// A step request goes through the queue, then the output register, to the output.
// One request per cycle when not stalled; each step is one add, compare and address sum.
// A four-entry command queue lets intake continue while the output stream is stalled.
// Reset (synchronous, rst high) empties the queue, drops the active line,
// clears the output valid and sets buffer_base to zero.
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top: streaming Bresenham line rasterizer
// Front end sets up lines, the command queue decouples it from the stepping
// engine, which emits one pixel with its frame-buffer address per step.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top import blr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,      // buffer_base
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // x_start, y_start, x_end, y_end, color
  input  logic [0:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_color, pixel_address
  output logic        m_axis_tlast    // last_pixel
);

  addr_t buffer_base;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_not_empty;
  cmd_t  q_in;
  cmd_t  q_head;

  // Hold the buffer base register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base <= '0;
    end else if (cfg_we) begin
      buffer_base <= cfg_wdata;
    end
  end

  blr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in)
  );

  blr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (q_head)
  );

  blr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .buffer_base   (buffer_base),
    .q_not_empty   (q_not_empty),
    .q_cmd         (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
